// File: sv/shape_fill_rasterizer_defines.svh
// ---------------------------------------------------------------------------
// shape_fill_rasterizer_defines.svh
// Assertion shorthands used by the rasterizer checker.
// ---------------------------------------------------------------------------
`ifndef SHAPE_FILL_RASTERIZER_DEFINES_SVH
`define SHAPE_FILL_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFR_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rasterizer check failed");

// Next-cycle implication, disabled during reset.
`define SFR_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rasterizer check failed");

`endif

// File: sv/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// Shared constants, codes and types of the shape fill rasterizer.
// ---------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_SIDE = 64;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int ADDR_W   = 2 * SIDE_W;
  // compare width for row/col counters against 7-bit canvas sizes
  localparam int CW       = ((SIDE_W > 7) ? SIDE_W : 7) + 1;
  // signed width for coverage arithmetic
  localparam int DW       = ((SIDE_W > 8) ? SIDE_W : 8) + 4;
  localparam int COUNT_W  = 13;

  localparam logic [7:0] BLANK_CELL = 8'd46;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  localparam logic [2:0] MODE_RECT    = 3'd0;
  localparam logic [2:0] MODE_UP      = 3'd1;
  localparam logic [2:0] MODE_DOWN    = 3'd2;
  localparam logic [2:0] MODE_DIAMOND = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] ax;     // two's complement
    logic [7:0] ay;     // two's complement
    logic [6:0] w;
    logic [6:0] h;
    logic [5:0] rad;
  } cmd_t;

endpackage

// File: sv/sfr_store.sv
// ---------------------------------------------------------------------------
// sfr_store
// Character frame store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module sfr_store
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/sfr_cover.sv
// ---------------------------------------------------------------------------
// sfr_cover
// Coverage test: does the latched shape cover cell (row, col)?
// ---------------------------------------------------------------------------
module sfr_cover
  import sfr_pkg::*;
(
  input  cmd_t              cmd,
  input  logic [SIDE_W-1:0] row,
  input  logic [SIDE_W-1:0] col,
  output logic              covered
);

  logic signed [DW-1:0] row_s, col_s, ax_s, ay_s, h_s, w_s, rad_s;
  logic signed [DW-1:0] dr, dn, dc, adc, dd, add, sum;

  always_comb begin
    row_s = $signed({{(DW-SIDE_W){1'b0}}, row});
    col_s = $signed({{(DW-SIDE_W){1'b0}}, col});
    ax_s  = $signed({{(DW-8){cmd.ax[7]}}, cmd.ax});
    ay_s  = $signed({{(DW-8){cmd.ay[7]}}, cmd.ay});
    h_s   = $signed({{(DW-7){1'b0}}, cmd.h});
    w_s   = $signed({{(DW-7){1'b0}}, cmd.w});
    rad_s = $signed({{(DW-6){1'b0}}, cmd.rad});

    dr  = row_s - ay_s;
    dn  = ay_s - row_s;
    dc  = col_s - ax_s;
    adc = (dc < 0) ? -dc : dc;
    dd  = dr - rad_s;
    add = (dd < 0) ? -dd : dd;
    sum = add + adc;

    unique case (cmd.mode)
      MODE_RECT:    covered = (dr >= 0) && (dr < h_s) && (dc >= 0) && (dc < w_s);
      MODE_UP:      covered = (dr >= 0) && (dr < h_s) && (adc <= dr);
      MODE_DOWN:    covered = (dn >= 0) && (dn < h_s) && (adc <= dn);
      MODE_DIAMOND: covered = (sum <= rad_s);
      default:      covered = 1'b0;
    endcase
  end

endmodule

// File: sv/shape_fill_rasterizer.sv
// ---------------------------------------------------------------------------
// shape_fill_rasterizer
// Clipped shape fill into a character frame store, with single-cell reads.
// ---------------------------------------------------------------------------
// After reset the block sweeps the whole store to '.' at one cell per cycle,
// with s_tready low; config writes are taken meanwhile. A command is then
// taken only in idle. A draw command (rectangle, up/down triangle, diamond)
// scans every canvas cell once, row by row, one cell per cycle through a
// single coverage unit and the store's write port, then posts the result.
// A read, an unused mode or a draw on an empty canvas goes from idle straight
// to posting; the registered store read is ready by then. The result sits in
// an output register, so a new command may be taken while it waits; posting
// the next result waits until that register is free.
// ---------------------------------------------------------------------------
module shape_fill_rasterizer
  import sfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // command stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [2:0] mode, [10:3] anchor_x, [18:11] anchor_y, [25:19] rect_width,
  // [32:26] shape_height, [38:33] radius, [46:39] brush, [52:47] read_row,
  // [58:53] read_col, [63:59] zero
  input  logic [63:0]           s_tdata,
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] cell_value, [8] cell_valid, [21:9] pixels_written, [23:22] zero
  output logic [23:0]           m_tdata
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;

  localparam int RW = (SIDE_W > 6) ? SIDE_W : 6;

  logic [2:0]          state;
  logic [ADDR_W-1:0]   clr_addr;
  logic [SIDE_W-1:0]   row, col;
  logic [6:0]          canvas_rows, canvas_cols;
  logic [6:0]          eff_rows, eff_cols;
  cmd_t                cmd;
  logic [7:0]          brush;
  logic [COUNT_W-1:0]  count;
  logic                is_read, rd_ok;

  // command field unpacking
  logic [2:0]  in_mode;
  logic [7:0]  in_ax, in_ay, in_brush;
  logic [6:0]  in_w, in_h;
  logic [5:0]  in_rad, in_rr, in_rc;
  logic [RW-1:0] rr_ext, rc_ext;
  logic        in_draw, in_read, in_rd_ok, canvas_empty;
  logic        accept, covered, col_last, row_last, out_free;

  // store ports
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  assign in_mode  = s_tdata[2:0];
  assign in_ax    = s_tdata[10:3];
  assign in_ay    = s_tdata[18:11];
  assign in_w     = s_tdata[25:19];
  assign in_h     = s_tdata[32:26];
  assign in_rad   = s_tdata[38:33];
  assign in_brush = s_tdata[46:39];
  assign in_rr    = s_tdata[52:47];
  assign in_rc    = s_tdata[58:53];
  assign rr_ext   = RW'(in_rr);
  assign rc_ext   = RW'(in_rc);

  // canvas sizes saturate at MAX_SIDE
  assign eff_rows = (CW'(canvas_rows) > CW'(MAX_SIDE)) ? 7'(MAX_SIDE) : canvas_rows;
  assign eff_cols = (CW'(canvas_cols) > CW'(MAX_SIDE)) ? 7'(MAX_SIDE) : canvas_cols;
  assign canvas_empty = (eff_rows == 7'd0) || (eff_cols == 7'd0);

  assign in_draw  = (in_mode == MODE_RECT) || (in_mode == MODE_UP) ||
                    (in_mode == MODE_DOWN) || (in_mode == MODE_DIAMOND);
  assign in_read  = (in_mode == MODE_READ);
  assign in_rd_ok = (CW'(in_rr) < CW'(eff_rows)) && (CW'(in_rc) < CW'(eff_cols));

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign col_last = (CW'(col) + CW'(1)) == CW'(eff_cols);
  assign row_last = (CW'(row) + CW'(1)) == CW'(eff_rows);

  // shared coverage unit, one cell per cycle
  sfr_cover u_cover (
    .cmd     (cmd),
    .row     (row),
    .col     (col),
    .covered (covered)
  );

  // store port muxing: clearing sweep or scan writes; reads on accept
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = BLANK_CELL;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == ST_SCAN) begin
      mem_we    = covered;
      mem_waddr = {row, col};
      mem_wdata = brush;
    end
  end

  assign mem_re    = accept && in_read;
  assign mem_raddr = {rr_ext[SIDE_W-1:0], rc_ext[SIDE_W-1:0]};

  sfr_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_rows <= 7'd10;
      canvas_cols <= 7'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: canvas_rows <= cfg_data;
        REG_COLS: canvas_cols <= cfg_data;
        default:  ;
      endcase
    end
  end

  // command payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.mode <= in_mode;
      cmd.ax   <= in_ax;
      cmd.ay   <= in_ay;
      cmd.w    <= in_w;
      cmd.h    <= in_h;
      cmd.rad  <= in_rad;
      brush    <= in_brush;
      is_read  <= in_read;
      rd_ok    <= in_read && in_rd_ok;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      row      <= '0;
      col      <= '0;
      count    <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            row   <= '0;
            col   <= '0;
            count <= '0;
            state <= (in_draw && !canvas_empty) ? ST_SCAN : ST_FIN;
          end
        end
        ST_SCAN: begin
          if (covered && (count != '1)) begin
            count <= count + COUNT_W'(1);
          end
          if (col_last) begin
            col <= '0;
            row <= row + SIDE_W'(1);
            if (row_last) begin
              state <= ST_FIN;
            end
          end else begin
            col <= col + SIDE_W'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result valid: set on posting, cleared by the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      m_tdata[7:0]   <= rd_ok ? mem_rdata : 8'd0;
      m_tdata[8]     <= rd_ok;
      m_tdata[21:9]  <= is_read ? '0 : count;
      m_tdata[23:22] <= 2'b00;
    end
  end

endmodule

// File: sv/sfr_checker.sv
// ---------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "shape_fill_rasterizer_defines.svh"

module sfr_checker
  import sfr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled result holds
  `SFR_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one command processed at a time: no back-to-back transfers in
  `SFR_ASSERT_NXT(a_one_cmd, clk, rst, s_tvalid && s_tready, !s_tready)

  // a valid read never reports a pixel count
  `SFR_ASSERT_IMP(a_read_no_count, clk, rst, m_tvalid && m_tdata[8], m_tdata[21:9] == 13'd0)

  // a nonzero cell value only comes with a valid read
  `SFR_ASSERT_IMP(a_value_valid, clk, rst, m_tvalid && (m_tdata[7:0] != 8'd0), m_tdata[8])

endmodule

bind shape_fill_rasterizer sfr_checker u_sfr_checker (.*);
